FILE: sv/itcf_pkg.sv
// ----------------------------------------------------------------------------
// itcf_pkg
// Shared types, constants and the arctangent table of the tilt filter.
// ----------------------------------------------------------------------------
`default_nettype none

package itcf_pkg;

  localparam int ANGLE_BITS        = 16;
  localparam int CORDIC_ITERS_DEF  = 16;
  localparam int CFG_INDEX_BITS    = 8;

  localparam logic [15:0] ALPHA_RESET      = 16'd64225;
  localparam logic [15:0] RATE_SCALE_RESET = 16'd1024;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA      = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_RATE_SCALE = CFG_INDEX_BITS'(1);

  typedef struct packed {
    logic               kind;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
  } in_item_t;

  typedef struct packed {
    logic [15:0] angle_x;
    logic [15:0] angle_y;
  } out_item_t;

  // arctangent of 2^-i in units of 2^-32 turn, truncated
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000002;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: sv/itcf_sqrt.sv
// ----------------------------------------------------------------------------
// itcf_sqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module itcf_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] radicand,
  output logic             done,
  output logic [15:0]      root
);

  logic        busy;
  logic [3:0]  cnt;
  logic [17:0] rem;
  logic [31:0] src;
  logic [17:0] rem_sh;
  logic [17:0] trial;
  logic        fits;

  always_comb begin
    rem_sh = {rem[15:0], src[31:30]};
    trial  = {root, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      src  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      src  <= {src[29:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[14:0], fits};
    end
  end

endmodule

`default_nettype wire

FILE: sv/itcf_cordic.sv
// ----------------------------------------------------------------------------
// itcf_cordic
// Iterative vectoring CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module itcf_cordic #(
  parameter int CORDIC_ITERS = itcf_pkg::CORDIC_ITERS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [15:0]        mag,
  input  wire logic signed [15:0] axis,
  output logic                    done,
  output logic [itcf_pkg::ANGLE_BITS-1:0] angle
);

  localparam int IW = $clog2(CORDIC_ITERS);

  logic                busy;
  logic [IW-1:0]       step;
  logic signed [26:0]  x;
  logic signed [26:0]  y;
  logic signed [33:0]  z;
  logic signed [26:0]  xs;
  logic signed [26:0]  ys;
  logic signed [33:0]  tab;
  logic signed [33:0]  z_rnd;

  always_comb begin
    xs    = x >>> step;
    ys    = y >>> step;
    tab   = $signed({2'b00, itcf_pkg::atan_entry(5'(step))});
    z_rnd = z + 34'sd32768;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + IW'(1);
        if (step == IW'(CORDIC_ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= $signed({3'b000, mag, 8'h00});
      y <= $signed({{3{axis[15]}}, axis, 8'h00});
      z <= '0;
    end else if (busy) begin
      if (!y[26]) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + tab;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - tab;
      end
    end
  end

  // round half up to the angle width
  assign angle = z_rnd[31:32-itcf_pkg::ANGLE_BITS];

endmodule

`default_nettype wire

FILE: sv/itcf_lane.sv
// ----------------------------------------------------------------------------
// itcf_lane
// One tilt axis: accelerometer angle, then seed or gyro blend of its state.
// ----------------------------------------------------------------------------
`default_nettype none

module itcf_lane #(
  parameter int CORDIC_ITERS = itcf_pkg::CORDIC_ITERS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               seed,
  input  wire logic signed [15:0] axis_a,
  input  wire logic signed [15:0] axis_b,
  input  wire logic signed [15:0] axis_c,
  input  wire logic signed [16:0] omega,
  input  wire logic [15:0]        alpha,
  input  wire logic [15:0]        rate_scale,
  output logic                    done,
  output logic [itcf_pkg::ANGLE_BITS-1:0] tilt
);

  localparam int AB = itcf_pkg::ANGLE_BITS;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ROOT   = 6'b000010,
    ST_ANGLE  = 6'b000100,
    ST_ERR    = 6'b001000,
    ST_PROD   = 6'b010000,
    ST_SUM    = 6'b100000
  } lane_state_t;

  lane_state_t state;

  logic [31:0]        radicand;
  logic               sq_done;
  logic [15:0]        root;
  logic               co_done;
  logic [AB-1:0]      co_angle;
  logic [AB-1:0]      folded;
  logic [AB-1:0]      acc;
  logic [AB-1:0]      raw;
  logic signed [AB:0] d;
  logic signed [34:0] e_next;
  logic signed [33:0] rate_term;
  logic signed [34:0] e;
  logic [31:0]        p_lo;
  logic signed [35:0] p_hi;
  logic signed [51:0] q_sum;
  logic [AB-1:0]      half;

  always_comb begin
    radicand = 32'(axis_b * axis_b) + 32'(axis_c * axis_c);
  end

  itcf_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .radicand (radicand),
    .done     (sq_done),
    .root     (root)
  );

  itcf_cordic #(
    .CORDIC_ITERS (CORDIC_ITERS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (sq_done),
    .mag   (root),
    .axis  (axis_a),
    .done  (co_done),
    .angle (co_angle)
  );

  always_comb begin
    half   = {1'b1, {(AB-1){1'b0}}};
    folded = axis_c[15] ? (half - co_angle) : co_angle;
    raw    = acc - tilt;
    if (raw > half) begin
      d = $signed({1'b0, raw}) - $signed({1'b1, {AB{1'b0}}});
    end else if (raw == half) begin
      d = (acc > tilt) ? $signed({1'b0, raw}) : -$signed({1'b0, raw});
    end else begin
      d = $signed({1'b0, raw});
    end
    rate_term = omega * $signed({1'b0, rate_scale});
    e_next    = -($signed(35'(d)) <<< 16) + 35'(rate_term);
    q_sum     = (52'(p_hi) <<< 16) + $signed({20'd0, p_lo}) + 52'sh80000000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      tilt  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (sq_done) begin
            state <= ST_ANGLE;
          end
        end
        ST_ANGLE: begin
          if (co_done) begin
            state <= ST_ERR;
          end
        end
        ST_ERR: begin
          if (seed) begin
            tilt  <= acc;
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            state <= ST_PROD;
          end
        end
        ST_PROD: begin
          state <= ST_SUM;
        end
        ST_SUM: begin
          tilt  <= acc + q_sum[32+AB-1:32];
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (co_done) begin
      acc <= folded;
    end
    if (state == ST_ERR) begin
      e <= e_next;
    end
    if (state == ST_PROD) begin
      p_lo <= {16'd0, alpha} * {16'd0, e[15:0]};
      p_hi <= $signed({1'b0, alpha}) * $signed(e[34:16]);
    end
  end

endmodule

`default_nettype wire

FILE: sv/imu_tilt_complementary_filter.sv
// ----------------------------------------------------------------------------
// imu_tilt_complementary_filter
// Two-axis tilt estimator blending accelerometer tilt with integrated gyro.
// path: from acceptance to result valid the item passes launch, root load,
//   16 square root steps, rotator load, CORDIC_ITERS rotations, fold, blend
//   steps (three for an update, one for a seed) and merge
// throughput: one item in flight at a time, since the root and CORDIC units
//   are iterative; a finished result waits in the output register while the
//   next item runs
// reset: synchronous, clears stored angles to zero and loads register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module imu_tilt_complementary_filter #(
  parameter int CORDIC_ITERS = itcf_pkg::CORDIC_ITERS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // input transactions
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire itcf_pkg::in_item_t                  in_data,
  // result transactions
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output itcf_pkg::out_item_t                      out_data,
  // register writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [itcf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [15:0]                         cfg_data
);

  localparam int AB = itcf_pkg::ANGLE_BITS;

  itcf_pkg::in_item_t item;
  logic               busy;
  logic               launch;
  logic               done_x;
  logic               done_y;
  logic               lane_done_x;
  logic               lane_done_y;
  logic [AB-1:0]      tilt_x;
  logic [AB-1:0]      tilt_y;
  logic [15:0]        alpha;
  logic [15:0]        rate_scale;
  logic signed [16:0] omega_x;
  logic signed [16:0] omega_y;
  logic               accept;
  logic               out_free;
  logic               finish;

  // register port never back-pressures
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha      <= itcf_pkg::ALPHA_RESET;
      rate_scale <= itcf_pkg::RATE_SCALE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        itcf_pkg::REG_ALPHA:      alpha      <= cfg_data;
        itcf_pkg::REG_RATE_SCALE: rate_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // one item in flight; the held item feeds both lanes until they finish
  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign out_free = !out_valid || !out_stall;
  assign finish   = busy && done_x && done_y && out_free;

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      launch <= 1'b0;
      done_x <= 1'b0;
      done_y <= 1'b0;
    end else begin
      launch <= accept;
      if (accept) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish) begin
        done_x <= 1'b0;
        done_y <= 1'b0;
      end else begin
        if (lane_done_x) done_x <= 1'b1;
        if (lane_done_y) done_y <= 1'b1;
      end
    end
  end

  // x axis rotates with minus gyro y, y axis with gyro x
  assign omega_x = -$signed({item.gyro_y[15], item.gyro_y});
  assign omega_y = $signed({item.gyro_x[15], item.gyro_x});

  itcf_lane #(
    .CORDIC_ITERS (CORDIC_ITERS)
  ) u_lane_x (
    .clk        (clk),
    .rst        (rst),
    .start      (launch),
    .seed       (item.kind),
    .axis_a     (item.accel_x),
    .axis_b     (item.accel_y),
    .axis_c     (item.accel_z),
    .omega      (omega_x),
    .alpha      (alpha),
    .rate_scale (rate_scale),
    .done       (lane_done_x),
    .tilt       (tilt_x)
  );

  itcf_lane #(
    .CORDIC_ITERS (CORDIC_ITERS)
  ) u_lane_y (
    .clk        (clk),
    .rst        (rst),
    .start      (launch),
    .seed       (item.kind),
    .axis_a     (item.accel_y),
    .axis_b     (item.accel_x),
    .axis_c     (item.accel_z),
    .omega      (omega_y),
    .alpha      (alpha),
    .rate_scale (rate_scale),
    .done       (lane_done_y),
    .tilt       (tilt_y)
  );

  // merge both lanes into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data.angle_x <= 16'(tilt_x);
      out_data.angle_y <= 16'(tilt_y);
    end
  end

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Tilt filter check: seeded and update transactions with random payloads,
// predicted in the testbench and compared field by field on every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  itcf_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  itcf_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [itcf_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  imu_tilt_complementary_filter uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [15:0] gain_alpha, gain_rate, held_x, held_y;
  // pending transactions and expected angles
  itcf_pkg::in_item_t   sample_queue[$];
  itcf_pkg::out_item_t  angle_queue[$];
  int         errors = 0;
  int         send_idle = 0;   // percent of cycles the sender stays idle
  int         recv_stall = 0;  // percent of cycles the receiver stalls
  int         hold_cycles = 0; // long receiver hold-off, counted down
  longint     cycles = 0;

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic longint shr(input longint v, input int k);
    return v >>> k; // arithmetic on signed longint
  endfunction

  // digit-by-digit integer square root, floor
  function automatic longint root_floor(input longint n);
    longint rem_v, r, b;
    rem_v = n;
    r = 0;
    b = longint'(1) << 62;
    while (b > rem_v) b = b >> 2;
    while (b != 0) begin
      if (rem_v >= r + b) begin
        rem_v = rem_v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // cordic atan2 of a against the root of b and c, folded by the sign of z
  function automatic logic [15:0] accel_tilt(input longint a, input longint b,
                                             input longint c, input longint z);
    longint x, y, acc, xn;
    logic [15:0] ang;
    x = root_floor(b * b + c * c) * 256;
    y = a * 256;
    acc = 0;
    for (int i = 0; i < itcf_pkg::CORDIC_ITERS_DEF; i++) begin
      if (y >= 0) begin
        xn = x + shr(y, i); y = y - shr(x, i); acc += longint'(atan_tab(i));
      end else begin
        xn = x - shr(y, i); y = y + shr(x, i); acc -= longint'(atan_tab(i));
      end
      x = xn;
    end
    ang = 16'(shr(acc + 32768, 16));
    if (z < 0) ang = 16'h8000 - ang;
    return ang;
  endfunction

  function automatic longint atan_tab(input int i);
    longint t[16] = '{64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
                      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                      64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
                      64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C};
    return t[i];
  endfunction

  // shortest-arc blend of gyro-propagated angle with accelerometer angle
  function automatic logic [15:0] fuse(input logic [15:0] held, input logic [15:0] acc,
                                       input longint omega);
    logic [15:0] raw;
    longint d, e, q;
    raw = acc - held;
    if (raw > 16'h8000) d = longint'(raw) - 65536;
    else if (raw == 16'h8000) d = (acc > held) ? 32768 : -32768;
    else d = longint'(raw);
    e = -d * 65536 + omega * longint'(gain_rate);
    q = shr(longint'(gain_alpha) * e + (longint'(1) << 31), 32);
    return acc + 16'(q);
  endfunction

  task automatic predict(input itcf_pkg::in_item_t s);
    logic [15:0] ax_ang, ay_ang;
    itcf_pkg::out_item_t o;
    ax_ang = accel_tilt(s.accel_x, s.accel_y, s.accel_z, s.accel_z);
    ay_ang = accel_tilt(s.accel_y, s.accel_x, s.accel_z, s.accel_z);
    if (s.kind) begin
      held_x = ax_ang; held_y = ay_ang;
    end else begin
      held_x = fuse(held_x, ax_ang, -longint'(s.gyro_y));
      held_y = fuse(held_y, ay_ang, longint'(s.gyro_x));
    end
    o.angle_x = held_x; o.angle_y = held_y;
    angle_queue.push_back(o);
  endtask

  // driver: next pending sample offered when the sender is not idle
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict(in_data);
        void'(sample_queue.pop_front());
      end
      if (in_valid && in_stall) begin
        // payload held while stalled
      end else if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_valid <= 1'b1;
        in_data  <= sample_queue[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with a counted long hold-off when requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  // monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    itcf_pkg::out_item_t w;
    if (!rst && out_valid && !out_stall) begin
      if (angle_queue.size() == 0) begin
        report("unexpected result", out_data.angle_x, 16'h0000);
      end else begin
        w = angle_queue.pop_front();
        if (out_data.angle_x !== w.angle_x) report("angle_x", out_data.angle_x, w.angle_x);
        if (out_data.angle_y !== w.angle_y) report("angle_y", out_data.angle_y, w.angle_y);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    if (cycles > 2000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [itcf_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == itcf_pkg::REG_ALPHA) gain_alpha = val;
    else if (idx == itcf_pkg::REG_RATE_SCALE) gain_rate = val;
  endtask

  task automatic drain();
    while (sample_queue.size() != 0 || in_valid || angle_queue.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic itcf_pkg::in_item_t pick(input int bias);
    itcf_pkg::in_item_t s;
    logic [95:0] r;
    logic [15:0] ext[4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
    r = {$urandom, $urandom, $urandom};
    s = r[$bits(itcf_pkg::in_item_t)-1:0];
    s.kind = ($urandom_range(19) == 0);
    if (bias && $urandom_range(3) == 0) s.accel_x = ext[$urandom_range(3)];
    if (bias && $urandom_range(3) == 0) s.accel_y = ext[$urandom_range(3)];
    if (bias && $urandom_range(3) == 0) s.accel_z = ext[$urandom_range(3)];
    if ($urandom_range(2) == 0) begin
      // gentle motion keeps the filter near equilibrium
      s.gyro_x = $signed(16'($urandom_range(400))) - 16'sd200;
      s.gyro_y = $signed(16'($urandom_range(400))) - 16'sd200;
    end
    return s;
  endfunction

  task automatic random_phase(input int count, input int idle, input int stall);
    send_idle = idle; recv_stall = stall;
    for (int i = 0; i < count; i++) sample_queue.push_back(pick(1));
    drain();
  endtask

  initial begin
    itcf_pkg::in_item_t s;
    gain_alpha = itcf_pkg::ALPHA_RESET; gain_rate = itcf_pkg::RATE_SCALE_RESET;
    held_x = '0; held_y = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: zero vector, zero z, negative z, extremes, seed then update
    s = '0;                                   sample_queue.push_back(s);
    s.kind = 1'b1; s.accel_z = 16'sd16384;    sample_queue.push_back(s);
    s = '0; s.accel_x = 16'sd5000;            sample_queue.push_back(s);
    s = '0; s.accel_z = -16'sd16384; s.accel_x = 16'sd3000; sample_queue.push_back(s);
    s = '0; s.kind = 1'b1; s.accel_z = -16'sd1; sample_queue.push_back(s);
    s = '{1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}; sample_queue.push_back(s);
    s = '{1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000}; sample_queue.push_back(s);
    s = '{1'b1, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000}; sample_queue.push_back(s);
    // half a turn apart: seeded at a bottom-up pose, then updated upright
    s = '{1'b1, 16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000}; sample_queue.push_back(s);
    s = '{1'b0, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000}; sample_queue.push_back(s);
    s = '{1'b0, 16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000}; sample_queue.push_back(s);
    s = '{1'b0, 16'h0100, 16'hFF00, 16'h4000, 16'h8000, 16'h7FFF}; sample_queue.push_back(s);
    drain();

    random_phase(300, 0, 0);
    write_reg(itcf_pkg::REG_ALPHA, 16'hFFFF); write_reg(itcf_pkg::REG_RATE_SCALE, 16'hFFFF);
    random_phase(300, 84, 0);
    write_reg(itcf_pkg::REG_ALPHA, 16'h0000); write_reg(itcf_pkg::REG_RATE_SCALE, 16'h0000);
    random_phase(300, 0, 84);
    write_reg(itcf_pkg::REG_ALPHA, 16'h8000); write_reg(itcf_pkg::REG_RATE_SCALE, 16'd300);
    random_phase(300, 14, 14);
    // out-of-range index must be ignored
    write_reg(itcf_pkg::CFG_INDEX_BITS'(2), 16'h1234);
    write_reg(itcf_pkg::CFG_INDEX_BITS'(255), 16'h0001);
    write_reg(itcf_pkg::REG_ALPHA, 16'($urandom));
    write_reg(itcf_pkg::REG_RATE_SCALE, 16'($urandom));
    // long receiver hold-off while the sender keeps offering
    hold_cycles = 800;
    random_phase(300, 0, 0);
    write_reg(itcf_pkg::REG_ALPHA, itcf_pkg::ALPHA_RESET);
    write_reg(itcf_pkg::REG_RATE_SCALE, itcf_pkg::RATE_SCALE_RESET);
    random_phase(400, 40, 40);

    if (errors == 0 && angle_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
sv/itcf_pkg.sv
sv/itcf_sqrt.sv
sv/itcf_cordic.sv
sv/itcf_lane.sv
sv/imu_tilt_complementary_filter.sv
test/testbench.sv
